[src/assert_macros.svh]
// Assertion macros shared by the RTL of the vector transform block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("implication check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

[src/v4mt_pkg.sv]
// Shared constants, types and the output saturation function of the vector transform.
`default_nettype none

package v4mt_pkg;

    // Fixed-point format and derived widths.
    localparam int FRAC_BITS  = 16;
    localparam int WORD_W     = 32;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int SUM_W      = PROD_W + 2;
    localparam int DIM        = 4;
    localparam int IDX_W      = 2;

    // Configuration port.
    localparam int NUM_REGS   = 8;
    localparam int REG_SEL_W  = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 2 * WORD_W;

    // Pipeline depth from input word to output word, and an occupancy counter width.
    localparam int PIPE_DEPTH = 5;
    localparam int CNT_W      = 3;

    // Fixed-point one, and the saturation limits.
    localparam logic [WORD_W-1:0] FIX_ONE  = WORD_W'(64'd1 << FRAC_BITS);
    localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef logic [WORD_W-1:0]                     t_word;
    typedef logic [DIM-1:0][WORD_W-1:0]            t_vec;
    typedef logic [DIM-1:0][DIM-1:0][WORD_W-1:0]   t_mat;
    typedef logic [DIM-1:0][DIM-1:0][PROD_W-1:0]   t_prod;
    typedef logic [1:0][DIM-1:0][PAIR_W-1:0]       t_pair;
    typedef logic [DIM-1:0][SUM_W-1:0]             t_sum;

    // Drop the fraction bits (rounding toward minus infinity) and clamp to 32 bits.
    function automatic t_word saturate(input logic [SUM_W-1:0] sum);
        logic signed [SUM_W-1:0]    shifted;
        logic [SUM_W-WORD_W:0]      upper;
        t_word                      result;
        shifted = $signed(sum) >>> FRAC_BITS;
        upper   = shifted[SUM_W-1:WORD_W-1];
        if ((&upper) || !(|upper)) begin
            result = shifted[WORD_W-1:0];
        end else if (shifted[SUM_W-1]) begin
            result = WORD_MIN;
        end else begin
            result = WORD_MAX;
        end
        return result;
    endfunction

endpackage

`default_nettype wire

[src/v4mt_cfg_regs.sv]
// Matrix configuration registers, two entries per 64-bit word.
`default_nettype none

module v4mt_cfg_regs (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [v4mt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [v4mt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output v4mt_pkg::t_mat                   o_mat
);

    v4mt_pkg::t_mat                 r_mat;
    logic                           w_hit;
    logic [v4mt_pkg::IDX_W-1:0]     w_row;
    logic                           w_half;

    // Writes are always taken; indexes past the register list are dropped.
    assign o_cfg_ready = 1'b1;
    assign w_hit  = (i_cfg_index[v4mt_pkg::CFG_IDX_W-1:v4mt_pkg::REG_SEL_W] == '0);
    assign w_row  = i_cfg_index[v4mt_pkg::REG_SEL_W-1:1];
    assign w_half = i_cfg_index[0];

    // Register file; reset loads the identity matrix.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < v4mt_pkg::DIM; r++) begin
                for (int c = 0; c < v4mt_pkg::DIM; c++) begin
                    r_mat[r][c] <= (r == c) ? v4mt_pkg::FIX_ONE : '0;
                end
            end
        end else if (i_cfg_valid && w_hit) begin
            r_mat[w_row][{w_half, 1'b0}] <= i_cfg_data[v4mt_pkg::WORD_W-1:0];
            r_mat[w_row][{w_half, 1'b1}] <= i_cfg_data[v4mt_pkg::CFG_DATA_W-1:v4mt_pkg::WORD_W];
        end
    end

    assign o_mat = r_mat;

endmodule

`default_nettype wire

[src/v4mt_mul_stage.sv]
// Input capture stage and the sixteen-product multiplier stage.
`default_nettype none

module v4mt_mul_stage (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  v4mt_pkg::t_vec       i_vec,
    input  v4mt_pkg::t_mat       i_mat,
    output logic                 o_valid,
    input  wire                  i_ready,
    output v4mt_pkg::t_prod      o_prod
);

    logic                   r_v0;
    logic                   r_v1;
    v4mt_pkg::t_vec         r_vec;
    v4mt_pkg::t_prod        r_prod;
    v4mt_pkg::t_prod        n_prod;
    logic                   w_s0_ready;
    logic                   w_s1_ready;

    // Signed 32x32 product, sign-extended to the full 64-bit result.
    function automatic logic [v4mt_pkg::PROD_W-1:0] PROD_MUL(
        input logic signed [v4mt_pkg::WORD_W-1:0] a,
        input logic signed [v4mt_pkg::WORD_W-1:0] b
    );
        logic signed [v4mt_pkg::PROD_W-1:0] p;
        p = a * b;
        return p;
    endfunction

    // A stage takes a new word when it is empty or its word moves on.
    assign w_s1_ready = !r_v1 || i_ready;
    assign w_s0_ready = !r_v0 || w_s1_ready;
    assign o_ready    = w_s0_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_v1 <= r_v0;
            end
            if (w_s0_ready) begin
                r_v0 <= i_valid;
            end
        end
    end

    // Every vector component times every matrix entry of its row.
    always_comb begin
        for (int r = 0; r < v4mt_pkg::DIM; r++) begin
            for (int c = 0; c < v4mt_pkg::DIM; c++) begin
                n_prod[r][c] = PROD_MUL(r_vec[r], i_mat[r][c]);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_s0_ready && i_valid) begin
            r_vec <= i_vec;
        end
        if (w_s1_ready && r_v0) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_v1;
    assign o_prod  = r_prod;

endmodule

`default_nettype wire

[src/v4mt_sum_stage.sv]
// Two-level adder tree that sums the four products of each column exactly.
`default_nettype none

module v4mt_sum_stage (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  v4mt_pkg::t_prod      i_prod,
    output logic                 o_valid,
    input  wire                  i_ready,
    output v4mt_pkg::t_sum       o_sum
);

    logic                   r_v2;
    logic                   r_v3;
    v4mt_pkg::t_pair        r_pair;
    v4mt_pkg::t_pair        n_pair;
    v4mt_pkg::t_sum         r_sum;
    v4mt_pkg::t_sum         n_sum;
    logic                   w_s2_ready;
    logic                   w_s3_ready;

    assign w_s3_ready = !r_v3 || i_ready;
    assign w_s2_ready = !r_v2 || w_s3_ready;
    assign o_ready    = w_s2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_s3_ready) begin
                r_v3 <= r_v2;
            end
            if (w_s2_ready) begin
                r_v2 <= i_valid;
            end
        end
    end

    // First level: rows 0+1 and rows 2+3 of each column, one bit of growth.
    always_comb begin
        for (int c = 0; c < v4mt_pkg::DIM; c++) begin
            n_pair[0][c] = v4mt_pkg::PAIR_W'($signed(i_prod[0][c]))
                         + v4mt_pkg::PAIR_W'($signed(i_prod[1][c]));
            n_pair[1][c] = v4mt_pkg::PAIR_W'($signed(i_prod[2][c]))
                         + v4mt_pkg::PAIR_W'($signed(i_prod[3][c]));
        end
    end

    // Second level: the full column sum.
    always_comb begin
        for (int c = 0; c < v4mt_pkg::DIM; c++) begin
            n_sum[c] = v4mt_pkg::SUM_W'($signed(r_pair[0][c]))
                     + v4mt_pkg::SUM_W'($signed(r_pair[1][c]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_ready && i_valid) begin
            r_pair <= n_pair;
        end
        if (w_s3_ready && r_v2) begin
            r_sum <= n_sum;
        end
    end

    assign o_valid = r_v3;
    assign o_sum   = r_sum;

endmodule

`default_nettype wire

[src/v4mt_sat_stage.sv]
// Output stage: fraction truncation, saturation and the output register.
`default_nettype none

module v4mt_sat_stage (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  v4mt_pkg::t_sum       i_sum,
    output logic                 o_valid,
    input  wire                  i_ready,
    output v4mt_pkg::t_vec       o_vec
);

    logic                   r_v4;
    v4mt_pkg::t_vec         r_vec;
    v4mt_pkg::t_vec         n_vec;
    logic                   w_s4_ready;

    assign w_s4_ready = !r_v4 || i_ready;
    assign o_ready    = w_s4_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_s4_ready) begin
            r_v4 <= i_valid;
        end
    end

    // Each column is scaled back to the word format and clamped.
    always_comb begin
        for (int c = 0; c < v4mt_pkg::DIM; c++) begin
            n_vec[c] = v4mt_pkg::saturate(i_sum[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s4_ready && i_valid) begin
            r_vec <= n_vec;
        end
    end

    assign o_valid = r_v4;
    assign o_vec   = r_vec;

endmodule

`default_nettype wire

[src/vector4_matrix_transform_core.sv]
// Top level of the row-vector by 4x4 matrix transform in signed Q16.16.
`default_nettype none

// Each word on the input channel is a row vector (x, y, z, w); the block returns
// one word per input, out[j] = x*m0j + y*m1j + z*m2j + w*m3j, with the column sum
// kept exact, the fraction bits dropped (rounding toward minus infinity) and the
// result clamped to the signed 32-bit range. For a three-component vector, drive
// w with 1.0 (0x00010000). The block takes one vector per clock cycle while the
// input is ready, and passes each accepted vector to the output through
// five register stages: an input register, the sixteen 32x32 multipliers, two
// adder levels and the saturating output register. Every stage carries its own
// valid bit, so bubbles close up behind a stalled output and the input stays ready
// until all five stages hold a word. The matrix lives in eight
// 64-bit registers (index 2*row + col/2, even column in the low half), resets to
// identity, and is written through the configuration channel, which is always
// ready; writes to indexes above 7 are ignored. Write the matrix only while no
// word is in flight.
module vector4_matrix_transform_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Input vector channel.
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire signed [v4mt_pkg::WORD_W-1:0]   i_vec_x,
    input  wire signed [v4mt_pkg::WORD_W-1:0]   i_vec_y,
    input  wire signed [v4mt_pkg::WORD_W-1:0]   i_vec_z,
    input  wire signed [v4mt_pkg::WORD_W-1:0]   i_vec_w,
    // Result channel.
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic signed [v4mt_pkg::WORD_W-1:0]  o_out_x,
    output logic signed [v4mt_pkg::WORD_W-1:0]  o_out_y,
    output logic signed [v4mt_pkg::WORD_W-1:0]  o_out_z,
    output logic signed [v4mt_pkg::WORD_W-1:0]  o_out_w,
    // Configuration write channel.
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire [v4mt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [v4mt_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    `include "assert_macros.svh"

    v4mt_pkg::t_mat         w_mat;
    v4mt_pkg::t_vec         w_in_vec;
    v4mt_pkg::t_prod        w_prod;
    v4mt_pkg::t_sum         w_sum;
    v4mt_pkg::t_vec         w_out_vec;
    logic                   w_mul_valid;
    logic                   w_sum_ready;
    logic                   w_sum_valid;
    logic                   w_sat_ready;
    logic                   w_in_fire;
    logic                   w_out_fire;
    logic                   w_held_full;
    logic                   w_over_full;
    logic [v4mt_pkg::CNT_W-1:0] r_inflight;
    logic [v4mt_pkg::CNT_W-1:0] n_inflight;

    assign w_in_vec[0] = i_vec_x;
    assign w_in_vec[1] = i_vec_y;
    assign w_in_vec[2] = i_vec_z;
    assign w_in_vec[3] = i_vec_w;

    // Matrix registers.
    v4mt_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_mat       (w_mat)
    );

    // Input register and multipliers.
    v4mt_mul_stage u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_vec   (w_in_vec),
        .i_mat   (w_mat),
        .o_valid (w_mul_valid),
        .i_ready (w_sum_ready),
        .o_prod  (w_prod)
    );

    // Column adder tree.
    v4mt_sum_stage u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mul_valid),
        .o_ready (w_sum_ready),
        .i_prod  (w_prod),
        .o_valid (w_sum_valid),
        .i_ready (w_sat_ready),
        .o_sum   (w_sum)
    );

    // Truncation, saturation and output register.
    v4mt_sat_stage u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sum_valid),
        .o_ready (w_sat_ready),
        .i_sum   (w_sum),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_vec   (w_out_vec)
    );

    assign o_out_x = w_out_vec[0];
    assign o_out_y = w_out_vec[1];
    assign o_out_z = w_out_vec[2];
    assign o_out_w = w_out_vec[3];

    // Count of words between the two handshakes, used by the checks below.
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_fire = o_out_valid && i_out_ready;

    always_comb begin
        n_inflight = r_inflight;
        if (w_in_fire && !w_out_fire) begin
            n_inflight = r_inflight + 1'b1;
        end else if (!w_in_fire && w_out_fire) begin
            n_inflight = r_inflight - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    // Every stage full with the output held, and a count past the stage total.
    assign w_held_full = o_out_valid && !i_out_ready
                      && (r_inflight == v4mt_pkg::CNT_W'(v4mt_pkg::PIPE_DEPTH));
    assign w_over_full = (r_inflight > v4mt_pkg::CNT_W'(v4mt_pkg::PIPE_DEPTH));

    // The input only stalls when every stage is full and the output is held.
    `ASSERT_IMPLIES(a_in_stall_only_when_full, i_clk, i_rst_n, !o_in_ready, w_held_full)
    // No result appears without an accepted input behind it.
    `ASSERT_IMPLIES(a_no_invented_result, i_clk, i_rst_n, r_inflight == '0, !o_out_valid)
    // The pipeline never holds more words than it has stages.
    `ASSERT_IMPLIES(a_occupancy_bound, i_clk, i_rst_n, 1'b1, !w_over_full)
    // A word accepted into an empty block is not visible at the output next cycle.
    `ASSERT_NEXT(a_min_latency, i_clk, i_rst_n, (r_inflight == '0) && w_in_fire, !o_out_valid)

endmodule

`default_nettype wire
